[rtl/core/pressure_click_classifier_assert.svh]
// Assertion macros for the pressure click classifier
`ifndef PRESSURE_CLICK_CLASSIFIER_ASSERT_SVH
`define PRESSURE_CLICK_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define PCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pcc assertion failed");

// Check that a condition on one cycle implies a consequence on the next.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc assertion failed");

`else

`define PCC_ASSERT(label, clk, rst_n, prop)
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/pcc_pkg.sv]
// Shared types and constants of the pressure click classifier
package pcc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int DIV_W     = 16;
    localparam int LEVEL_W   = 25;
    localparam int DELTA_W   = 26;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // one quotient bit per step over the magnitude of the tare-corrected sample
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [TIME_W-1:0] HOLD_RESET_MS = 32'd120000;

    localparam logic [CFG_IDX_W-1:0] CFG_TARE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd6;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_RIGHT   = 3'd1,
        ACT_DOUBLE  = 3'd2,
        ACT_PRESS   = 3'd3,
        ACT_RELEASE = 3'd4
    } t_action;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic commit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

[rtl/core/pcc_ctrl.sv]
// Sequencing controller of the pressure click classifier
module pcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pcc_pkg::t_status i_status,
    output pcc_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import pcc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_FINISH,
        S_COMMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DIVIDE;
                        r_cnt   <= '0;
                        r_busy  <= 1'b1;
                    end
                end
                S_DIVIDE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    // wait for the output register to be free
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step   = (r_state == S_DIVIDE);
        o_cmd.finish = (r_state == S_FINISH);
        o_cmd.commit = (r_state == S_COMMIT) && i_status.out_free;
    end

    assign o_busy = r_busy;

endmodule

[rtl/core/pcc_datapath.sv]
// Divider, decision logic, state and output register of the classifier
module pcc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcc_pkg::t_cmd                   i_cmd,
    output pcc_pkg::t_status                o_status,
    input  logic                            i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic [pcc_pkg::SAMPLE_W-1:0]    i_pressure_sample,
    input  logic [pcc_pkg::TIME_W-1:0]      i_now_ms,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [2:0]                      o_button_action,
    output logic                            o_hold_entered,
    output logic                            o_reset_request,
    output logic [pcc_pkg::DELTA_W-1:0]     o_level_change
);
    import pcc_pkg::*;

    // configuration
    logic [SAMPLE_W-1:0] r_tare;
    logic [DIV_W-1:0]    r_div_cfg;
    logic [LEVEL_W-1:0]  r_press_thr;
    logic [LEVEL_W-1:0]  r_double_thr;
    logic [LEVEL_W-1:0]  r_right_thr;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   r_hold;

    // working registers of the current sample
    logic [TIME_W-1:0]   r_now;
    logic                r_neg;
    logic [DIV_W-1:0]    r_div;
    logic [DIV_W-1:0]    r_rem;
    logic [SAMPLE_W-1:0] r_quo;
    logic [LEVEL_W-1:0]  r_scaled;
    logic [DELTA_W-1:0]  r_delta;

    // classifier state
    logic [LEVEL_W-1:0]  r_ref;
    logic                r_btn;
    logic                r_right_done;
    logic                r_double_done;
    logic                r_hold_mode;
    logic [TIME_W-1:0]   r_idle_since;

    // output register
    logic                r_out_valid;
    t_action             r_act;
    logic                r_entered;
    logic                r_reset_req;
    logic [DELTA_W-1:0]  r_level;

    logic [LEVEL_W-1:0]  diff;
    logic [LEVEL_W-1:0]  mag;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      trial_sub;
    logic [LEVEL_W-1:0]  quo_ext;
    logic [LEVEL_W-1:0]  scaled;

    logic                gt_right;
    logic                gt_double;
    logic                gt_press;
    logic                lt_press;
    logic                started;
    logic [TIME_W-1:0]   since_idle;

    t_action             n_act;
    logic                n_entered;
    logic                n_reset_req;
    logic [LEVEL_W-1:0]  n_ref;
    logic                n_btn;
    logic                n_right_done;
    logic                n_double_done;
    logic                n_hold_mode;
    logic [TIME_W-1:0]   n_idle_since;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare       <= '0;
            r_div_cfg    <= DIV_W'(1);
            r_press_thr  <= '0;
            r_double_thr <= '0;
            r_right_thr  <= '0;
            r_start      <= '0;
            r_hold       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARE:   r_tare       <= i_cfg_data[SAMPLE_W-1:0];
                CFG_DIV:    r_div_cfg    <= i_cfg_data[DIV_W-1:0];
                CFG_PRESS:  r_press_thr  <= i_cfg_data[LEVEL_W-1:0];
                CFG_DOUBLE: r_double_thr <= i_cfg_data[LEVEL_W-1:0];
                CFG_RIGHT:  r_right_thr  <= i_cfg_data[LEVEL_W-1:0];
                CFG_START:  r_start      <= i_cfg_data[TIME_W-1:0];
                CFG_HOLD:   r_hold       <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // tare correction and magnitude for the unsigned divider
    always_comb begin
        diff = {i_pressure_sample[SAMPLE_W-1], i_pressure_sample}
             - {r_tare[SAMPLE_W-1], r_tare};
        mag  = diff[LEVEL_W-1] ? (LEVEL_W'(0) - diff) : diff;
    end

    // one restoring division step
    always_comb begin
        trial     = {r_rem, r_quo[SAMPLE_W-1]};
        trial_sub = trial - {1'b0, r_div};
    end

    // sign correction and level change
    always_comb begin
        quo_ext = {1'b0, r_quo};
        scaled  = r_neg ? (LEVEL_W'(0) - quo_ext) : quo_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_now_ms;
            r_neg <= diff[LEVEL_W-1];
            r_div <= (r_div_cfg == '0) ? DIV_W'(1) : r_div_cfg;
            r_rem <= '0;
            r_quo <= mag[SAMPLE_W-1:0];
        end else if (i_cmd.step) begin
            if (!trial_sub[DIV_W]) begin
                r_rem <= trial_sub[DIV_W-1:0];
                r_quo <= {r_quo[SAMPLE_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[SAMPLE_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_scaled <= scaled;
            r_delta  <= {scaled[LEVEL_W-1], scaled} - {r_ref[LEVEL_W-1], r_ref};
        end
    end

    // decision on the registered level change
    always_comb begin
        gt_right   = $signed(r_delta) > $signed({r_right_thr[LEVEL_W-1], r_right_thr});
        gt_double  = $signed(r_delta) > $signed({r_double_thr[LEVEL_W-1], r_double_thr});
        gt_press   = $signed(r_delta) > $signed({r_press_thr[LEVEL_W-1], r_press_thr});
        lt_press   = $signed(r_delta) < $signed({r_press_thr[LEVEL_W-1], r_press_thr});
        started    = r_now > r_start;
        since_idle = r_now - r_idle_since;

        n_act         = ACT_NONE;
        n_entered     = 1'b0;
        n_reset_req   = 1'b0;
        n_ref         = r_ref;
        n_btn         = r_btn;
        n_right_done  = r_right_done;
        n_double_done = r_double_done;
        n_hold_mode   = r_hold_mode;
        n_idle_since  = r_idle_since;

        if (!r_hold_mode) begin
            if (gt_right && !r_right_done && started) begin
                n_act        = ACT_RIGHT;
                n_btn        = 1'b1;
                n_right_done = 1'b1;
                n_ref        = r_scaled;
            end else if (gt_double && !r_double_done && started) begin
                n_act         = ACT_DOUBLE;
                n_btn         = 1'b1;
                n_double_done = 1'b1;
                n_ref         = r_scaled;
            end else if (gt_press && !r_btn && started) begin
                n_act = ACT_PRESS;
                n_btn = 1'b1;
                if (since_idle > r_hold) begin
                    n_hold_mode = 1'b1;
                    n_entered   = 1'b1;
                end
            end else if (lt_press && r_btn) begin
                n_act         = ACT_RELEASE;
                n_btn         = 1'b0;
                n_right_done  = 1'b0;
                n_double_done = 1'b0;
            end
            // track the level while the button is up
            if (!n_btn) begin
                n_ref        = r_scaled;
                n_idle_since = r_now;
            end
        end else begin
            if (gt_press) begin
                n_act       = ACT_RELEASE;
                n_btn       = 1'b0;
                n_hold_mode = 1'b0;
            end
            if (since_idle > HOLD_RESET_MS) begin
                n_reset_req = 1'b1;
            end
            n_ref = r_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref         <= '0;
            r_btn         <= 1'b0;
            r_right_done  <= 1'b0;
            r_double_done <= 1'b0;
            r_hold_mode   <= 1'b0;
            r_idle_since  <= '0;
        end else if (i_cmd.commit) begin
            r_ref         <= n_ref;
            r_btn         <= n_btn;
            r_right_done  <= n_right_done;
            r_double_done <= n_double_done;
            r_hold_mode   <= n_hold_mode;
            r_idle_since  <= n_idle_since;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_act       <= n_act;
            r_entered   <= n_entered;
            r_reset_req <= n_reset_req;
            r_level     <= r_delta;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_button_action = r_act;
    assign o_hold_entered  = r_entered;
    assign o_reset_request = r_reset_req;
    assign o_level_change  = r_level;

endmodule

[rtl/core/pressure_click_classifier.sv]
// Top level of the pressure click classifier
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_pressure_sample, i_now_ms
//   output    out        o_out_valid / i_out_stall  o_button_action, o_hold_entered,
//                                                   o_reset_request, o_level_change
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// The load happens on the transfer edge, then come 24 steps of the restoring divider
// (one quotient bit per cycle), then the finish step sign-corrects and forms the level
// change and the commit step decides and commits. The next transfer is taken the cycle
// after the commit, so a new sample is not taken before the last one is committed.
// A stalled output delays the commit for as long as it waits.
// Synchronous active-low reset clears configuration to its defaults and all
// classifier state to zero. A new sample is taken while a result waits in the
// output register; it is held at the decision step until that register is free.
`include "pressure_click_classifier_assert.svh"

module pressure_click_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pcc_pkg::SAMPLE_W-1:0]    i_pressure_sample,
    input  logic [pcc_pkg::TIME_W-1:0]      i_now_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_button_action,
    output logic                            o_hold_entered,
    output logic                            o_reset_request,
    output logic [pcc_pkg::DELTA_W-1:0]     o_level_change,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcc_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import pcc_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;

    // registers are written in any cycle; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    // hold off the next transfer until the current sample is committed
    assign o_in_stall = busy;

    pcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    pcc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pressure_sample (i_pressure_sample),
        .i_now_ms          (i_now_ms),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_button_action   (o_button_action),
        .o_hold_entered    (o_hold_entered),
        .o_reset_request   (o_reset_request),
        .o_level_change    (o_level_change)
    );

    // a transfer always leaves the block busy in the next cycle
    `PCC_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a commit presents a result and frees the input side
    `PCC_ASSERT_NEXT(a_commit_result, i_clk, i_rst_n, cmd.commit, o_out_valid && !o_in_stall)
    // hold mode is entered only by a plain press
    `PCC_ASSERT(a_hold_on_press, i_clk, i_rst_n,
        !(o_out_valid && o_hold_entered) || (o_button_action == ACT_PRESS))

endmodule
